### hw/rtl/wsfp_pkg.sv
// Shared types and codes for the WebSocket frame parser.
// Holds the result record and the result kind codes; no dependencies.
package wsfp_pkg;

  // Result kinds carried on the result channel's tuser.
  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  // Widths of the stream words.
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 120;
  localparam int unsigned OUT_USER_W = 2;

  // One parsed result as it travels from the parser to the result register.
  typedef struct packed {
    logic [1:0]  kind;
    logic        fin;
    logic        rsv1;
    logic        rsv2;
    logic        rsv3;
    logic [3:0]  frame_opcode;
    logic        masked;
    logic [63:0] body_len;
    logic [31:0] mask_key;
    logic [7:0]  payload_byte;
    logic        last;
  } res_t;

endpackage

### hw/rtl/wsfp_in_reg.sv
// Input register stage of the WebSocket frame parser.
// Holds one stream byte until the parser takes it; uses wsfp_pkg.
module wsfp_in_reg
  import wsfp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,
  input  logic                 take,
  output logic                 vld,
  output logic [IN_DATA_W-1:0] data
);

  logic                 vld_r;
  logic [IN_DATA_W-1:0] data_r;

  // A new request may enter when the stage is empty or being drained now.
  assign in_tready = !vld_r || take;
  assign vld       = vld_r;
  assign data      = data_r;

  // Valid flag of the held byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      vld_r <= 1'b1;
    end else if (take) begin
      vld_r <= 1'b0;
    end
  end

  // Byte payload, no reset needed.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      data_r <= in_tdata;
    end
  end

endmodule

### hw/rtl/wsfp_parse.sv
// Frame decoder of the WebSocket frame parser: header state and payload unmasking.
// Consumes one byte per step and forms at most one result; uses wsfp_pkg.
module wsfp_parse
  import wsfp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic [IN_DATA_W-1:0] data,
  output logic                 res_vld,
  output res_t                 res
);

  // Parse phases.
  localparam logic [2:0] PH_FIRST   = 3'd0;
  localparam logic [2:0] PH_SECOND  = 3'd1;
  localparam logic [2:0] PH_EXTLEN  = 3'd2;
  localparam logic [2:0] PH_KEY     = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;

  // Accepted opcodes.
  localparam logic [3:0] OP_CONT  = 4'h0;
  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_BIN   = 4'h2;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;
  localparam logic [3:0] OP_PONG  = 4'hA;

  // Short length codes that select an extended length.
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  // Header bits: [8] fin, [7:5] rsv1..3, [4:1] opcode, [0] mask.
  logic [2:0]  phase_r,  phase_nxt;
  logic [3:0]  cnt_r,    cnt_nxt;
  logic [8:0]  hb_r,     hb_nxt;
  logic [63:0] len_r,    len_nxt;
  logic [31:0] key_r,    key_nxt;
  logic [63:0] rem_r,    rem_nxt;
  logic [1:0]  kpos_r,   kpos_nxt;

  logic        do_finish;
  logic [8:0]  fin_hb;
  logic [63:0] fin_len;
  logic [31:0] fin_key;
  logic        fin_last;
  logic [3:0]  op;
  logic        op_ok;
  logic [7:0]  kb;

  function automatic res_t make_res(input logic [1:0] kind, input logic [8:0] hb,
                                    input logic [63:0] len, input logic [31:0] key,
                                    input logic [7:0] pbyte, input logic last);
    res_t r;
    r.kind           = kind;
    r.fin            = hb[8];
    r.rsv1           = hb[7];
    r.rsv2           = hb[6];
    r.rsv3           = hb[5];
    r.frame_opcode   = hb[4:1];
    r.masked         = hb[0];
    r.body_len       = len;
    r.mask_key       = hb[0] ? key : 32'd0;
    r.payload_byte   = pbyte;
    r.last           = last;
    return r;
  endfunction

  assign op    = data[3:0];
  assign op_ok = (op == OP_CONT) || (op == OP_TEXT) || (op == OP_BIN) ||
                 (op == OP_CLOSE) || (op == OP_PING) || (op == OP_PONG);

  // Key byte for the current payload position, first key byte first.
  always_comb begin
    case (kpos_r)
      2'd0:    kb = key_r[31:24];
      2'd1:    kb = key_r[23:16];
      2'd2:    kb = key_r[15:8];
      default: kb = key_r[7:0];
    endcase
  end

  // Next state and result for the byte taken in this step.
  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    hb_nxt    = hb_r;
    len_nxt   = len_r;
    key_nxt   = key_r;
    rem_nxt   = rem_r;
    kpos_nxt  = kpos_r;
    res_vld   = 1'b0;
    res       = '0;
    do_finish = 1'b0;
    fin_hb    = hb_r;
    fin_len   = len_r;
    fin_key   = key_r;

    case (phase_r)
      PH_SECOND: begin
        hb_nxt  = {hb_r[8:1], data[7]};
        key_nxt = 32'd0;
        len_nxt = 64'd0;
        if (data[6:0] == LEN_EXT16) begin
          cnt_nxt   = 4'd2;
          phase_nxt = PH_EXTLEN;
        end else if (data[6:0] == LEN_EXT64) begin
          cnt_nxt   = 4'd8;
          phase_nxt = PH_EXTLEN;
        end else begin
          len_nxt = {57'd0, data[6:0]};
          if (data[7]) begin
            cnt_nxt   = 4'd4;
            phase_nxt = PH_KEY;
          end else begin
            do_finish = 1'b1;
            fin_hb    = hb_nxt;
            fin_len   = len_nxt;
            fin_key   = 32'd0;
          end
        end
      end
      PH_EXTLEN: begin
        len_nxt = {len_r[55:0], data};
        cnt_nxt = cnt_r - 4'd1;
        if (cnt_nxt == 4'd0) begin
          if (hb_r[0]) begin
            cnt_nxt   = 4'd4;
            phase_nxt = PH_KEY;
          end else begin
            do_finish = 1'b1;
            fin_len   = len_nxt;
          end
        end
      end
      PH_KEY: begin
        key_nxt = {key_r[23:0], data};
        cnt_nxt = cnt_r - 4'd1;
        if (cnt_nxt == 4'd0) begin
          do_finish = 1'b1;
          fin_key   = key_nxt;
        end
      end
      PH_PAYLOAD: begin
        rem_nxt  = rem_r - 64'd1;
        res_vld  = 1'b1;
        res      = make_res(KIND_PAYLOAD, hb_r, len_r, key_r,
                            data ^ (hb_r[0] ? kb : 8'd0), rem_nxt == 64'd0);
        kpos_nxt = kpos_r + 2'd1;
        if (rem_nxt == 64'd0) begin
          phase_nxt = PH_FIRST;
        end
      end
      default: begin
        // First header byte; a rejected opcode reports an error and restarts.
        if (!op_ok) begin
          res_vld   = 1'b1;
          res       = make_res(KIND_ERROR, {data[7:4], op, 1'b0}, 64'd0, 32'd0,
                               8'd0, 1'b1);
          phase_nxt = PH_FIRST;
        end else begin
          hb_nxt    = {data[7:4], op, 1'b0};
          phase_nxt = PH_SECOND;
        end
      end
    endcase

    // Header complete: report it and move on to the payload or the next frame.
    fin_last = (fin_len == 64'd0);
    if (do_finish) begin
      res_vld = 1'b1;
      res     = make_res(KIND_HEADER, fin_hb, fin_len, fin_key, 8'd0, fin_last);
      if (fin_last) begin
        phase_nxt = PH_FIRST;
      end else begin
        rem_nxt   = fin_len;
        kpos_nxt  = 2'd0;
        phase_nxt = PH_PAYLOAD;
      end
    end
  end

  // Parser state, advanced once per byte taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FIRST;
      cnt_r   <= 4'd0;
      hb_r    <= 9'd0;
      len_r   <= 64'd0;
      key_r   <= 32'd0;
      rem_r   <= 64'd0;
      kpos_r  <= 2'd0;
    end else if (step) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      hb_r    <= hb_nxt;
      len_r   <= len_nxt;
      key_r   <= key_nxt;
      rem_r   <= rem_nxt;
      kpos_r  <= kpos_nxt;
    end
  end

endmodule

### hw/rtl/wsfp_out_reg.sv
// Result register of the WebSocket frame parser.
// Packs one result into the stream word and holds it until taken; uses wsfp_pkg.
module wsfp_out_reg
  import wsfp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  res_t                  res,
  output logic                  can_load,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [OUT_USER_W-1:0] out_tuser,
  output logic                  out_tlast
);

  logic                  vld_r;
  logic [OUT_DATA_W-1:0] data_r;
  logic [OUT_USER_W-1:0] user_r;
  logic                  last_r;

  // The register may be refilled when empty or when its request leaves now.
  assign can_load   = !vld_r || out_tready;
  assign out_tvalid = vld_r;
  assign out_tdata  = data_r;
  assign out_tuser  = user_r;
  assign out_tlast  = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (load) begin
      vld_r <= 1'b1;
    end else if (out_tready) begin
      vld_r <= 1'b0;
    end
  end

  // Pack the fields from the lowest bit up, zero fill to whole bytes.
  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= {7'd0, res.payload_byte, res.mask_key, res.body_len, res.masked,
                 res.frame_opcode, res.rsv3, res.rsv2, res.rsv1, res.fin};
      user_r <= res.kind;
      last_r <= res.last;
    end
  end

endmodule

### hw/rtl/websocket_frame_parser_unit.sv
// WebSocket (RFC 6455) frame parser, top level. Bytes enter one per request on the
// input stream and wait in the input register; each is then decoded and its result, if
// any, loaded into the result register, so the block takes one byte per clock while the
// result register can be loaded. That rate is set by the single decode step between the
// input and result registers, which carries the header state, the 64-bit remaining-length
// count and the key index. Header and error results come out once per frame; payload bytes
// come out unmasked. Uses wsfp_pkg, wsfp_in_reg, wsfp_parse and wsfp_out_reg.
module websocket_frame_parser_unit
  import wsfp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [7:0] data_byte
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [0] fin, [1] rsv1, [2] rsv2, [3] rsv3, [7:4] frame_opcode, [8] masked,
  // [72:9] body_len, [104:73] mask_key, [112:105] payload_byte, [119:113] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [OUT_USER_W-1:0] out_tuser,  // [1:0] kind
  output logic                  out_tlast   // last
);

  logic                 byte_vld;
  logic [IN_DATA_W-1:0] byte_data;
  logic                 can_load;
  logic                 step;
  logic                 res_vld;
  res_t                 res;

  // A held byte is parsed whenever the result register can take its outcome.
  assign step = byte_vld && can_load;

  wsfp_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .take      (step),
    .vld       (byte_vld),
    .data      (byte_data)
  );

  wsfp_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .data    (byte_data),
    .res_vld (res_vld),
    .res     (res)
  );

  wsfp_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (step && res_vld),
    .res        (res),
    .can_load   (can_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
